/* hdl/trpq_pkg.sv */
// shared types and constants of the timed release priority queue
// depends on nothing; used by every module under hdl
package trpq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int TIME_W      = 32;
	localparam int TAG_W       = 32;

	// stream payload widths
	localparam int IN_TDATA_W  = 3 * 32;
	localparam int OUT_TDATA_W = ((TIME_W + TAG_W + CNT_W + 7) / 8) * 8;

	typedef enum logic [0:0] {
		REQ_PUSH = 1'b0,
		REQ_PEEK = 1'b1
	} req_t;

	typedef enum logic [2:0] {
		ST_RELEASED = 3'd0,
		ST_WAIT     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_ACCEPTED = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef struct packed {
		logic [TIME_W-1:0] rtime;
		logic [TAG_W-1:0]  payload;
	} entry_t;

	// one write and one read per cycle, indexes are logical (0 = head)
	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		entry_t           wr_data;
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
	} mem_cmd_t;

	typedef struct packed {
		status_t           status;
		logic [TIME_W-1:0] rtime;
		logic [TAG_W-1:0]  payload;
		logic [CNT_W-1:0]  count;
	} result_t;

endpackage

/* hdl/trpq_store.sv */
// entry memory of the queue, kept as a ring addressed from the head
// depends on trpq_pkg
module trpq_store (
	input  logic                    clk,
	input  trpq_pkg::mem_cmd_t      cmd,
	input  logic [trpq_pkg::IDX_W-1:0] head,
	output trpq_pkg::entry_t        rd_data
);

	localparam logic [trpq_pkg::IDX_W:0] DEPTH_X =
		(trpq_pkg::IDX_W + 1)'(trpq_pkg::QUEUE_DEPTH);

	trpq_pkg::entry_t mem_q [trpq_pkg::QUEUE_DEPTH];
	trpq_pkg::entry_t rd_q;

	logic [trpq_pkg::IDX_W-1:0] wr_addr;
	logic [trpq_pkg::IDX_W-1:0] rd_addr;

	// logical position to ring slot
	function automatic logic [trpq_pkg::IDX_W-1:0] to_phys(
		input logic [trpq_pkg::IDX_W-1:0] hd,
		input logic [trpq_pkg::IDX_W-1:0] lidx
	);
		logic [trpq_pkg::IDX_W:0] sum;
		sum = {1'b0, hd} + {1'b0, lidx};
		if (sum >= DEPTH_X) begin
			sum = sum - DEPTH_X;
		end
		return sum[trpq_pkg::IDX_W-1:0];
	endfunction

	assign wr_addr = to_phys(head, cmd.wr_idx);
	assign rd_addr = to_phys(head, cmd.rd_idx);

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_addr] <= cmd.wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

/* hdl/trpq_ctrl.sv */
// sequencer: sorted insert scan, head release with rate limit, counters
// depends on trpq_pkg; drives trpq_store and feeds trpq_outreg
module trpq_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  trpq_pkg::req_t              in_req,
	input  logic [trpq_pkg::TIME_W-1:0] in_rtime,
	input  logic [trpq_pkg::TAG_W-1:0]  in_tag,
	input  logic [trpq_pkg::TIME_W-1:0] in_now,
	input  logic [trpq_pkg::TIME_W-1:0] min_interval,
	output trpq_pkg::mem_cmd_t          cmd,
	output logic [trpq_pkg::IDX_W-1:0]  head,
	input  trpq_pkg::entry_t            rd_data,
	output logic                        res_valid,
	input  logic                        res_ready,
	output trpq_pkg::result_t           res
);

	typedef enum logic [2:0] {
		IDLE,
		PUSH_SCAN,
		PUSH_HEAD,
		PEEK_CHK,
		RESP
	} state_t;

	localparam logic [trpq_pkg::CNT_W-1:0] FULL_CNT =
		trpq_pkg::CNT_W'(trpq_pkg::QUEUE_DEPTH);
	localparam logic [trpq_pkg::IDX_W-1:0] LAST_SLOT =
		trpq_pkg::IDX_W'(trpq_pkg::QUEUE_DEPTH - 1);

	state_t                       state_q;
	logic [trpq_pkg::CNT_W-1:0]   cnt_q;
	logic [trpq_pkg::IDX_W-1:0]   hd_q;
	logic [trpq_pkg::TIME_W-1:0]  last_q;
	logic [trpq_pkg::IDX_W-1:0]   j_q;
	logic [trpq_pkg::TIME_W-1:0]  t_q;
	logic [trpq_pkg::TAG_W-1:0]   tag_q;
	logic [trpq_pkg::TIME_W-1:0]  now_q;
	trpq_pkg::result_t            res_q;

	logic [trpq_pkg::TIME_W-1:0]  t_clamp;
	logic [trpq_pkg::IDX_W-1:0]   last_idx;
	logic [trpq_pkg::IDX_W-1:0]   hd_next;
	logic                         shift_on;
	logic                         interval_ok;
	logic                         due;
	logic                         release_ok;
	trpq_pkg::entry_t             new_entry;

	// negative release time counts as zero
	assign t_clamp     = in_rtime[trpq_pkg::TIME_W-1] ? '0 : in_rtime;
	assign last_idx    = trpq_pkg::IDX_W'(cnt_q - trpq_pkg::CNT_W'(1));
	assign hd_next     = (hd_q == LAST_SLOT) ? '0 : hd_q + trpq_pkg::IDX_W'(1);
	assign shift_on    = rd_data.rtime > t_q;
	assign interval_ok = (now_q >= last_q) && ((now_q - last_q) >= min_interval);
	assign due         = rd_data.rtime <= now_q;
	assign release_ok  = interval_ok && due;
	assign new_entry   = '{rtime: t_q, payload: tag_q};

	assign in_ready  = (state_q == IDLE);
	assign res_valid = (state_q == RESP);
	assign res       = res_q;
	assign head      = hd_q;

	// memory commands; read data shows up in the following state
	always_comb begin
		cmd = '0;
		unique case (state_q)
			IDLE: begin
				if (in_valid) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_idx = (in_req == trpq_pkg::REQ_PEEK) ? '0 : last_idx;
				end
			end
			PUSH_SCAN: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_idx = j_q + trpq_pkg::IDX_W'(1);
				if (shift_on) begin
					cmd.wr_data = rd_data;
					if (j_q != '0) begin
						cmd.rd_en  = 1'b1;
						cmd.rd_idx = j_q - trpq_pkg::IDX_W'(1);
					end
				end else begin
					cmd.wr_data = new_entry;
				end
			end
			PUSH_HEAD: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_idx  = '0;
				cmd.wr_data = new_entry;
			end
			PEEK_CHK, RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q   <= '0;
			hd_q    <= '0;
			last_q  <= '0;
			j_q     <= '0;
			t_q     <= '0;
			tag_q   <= '0;
			now_q   <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						t_q   <= t_clamp;
						tag_q <= in_tag;
						now_q <= in_now;
						if (in_req == trpq_pkg::REQ_PEEK) begin
							if (cnt_q == '0) begin
								res_q   <= '{trpq_pkg::ST_EMPTY, '0, '0, cnt_q};
								state_q <= RESP;
							end else begin
								state_q <= PEEK_CHK;
							end
						end else if (cnt_q == FULL_CNT) begin
							res_q   <= '{trpq_pkg::ST_FULL, '0, '0, cnt_q};
							state_q <= RESP;
						end else if (cnt_q == '0) begin
							state_q <= PUSH_HEAD;
						end else begin
							j_q     <= last_idx;
							state_q <= PUSH_SCAN;
						end
					end
				end
				PUSH_SCAN: begin
					if (shift_on) begin
						if (j_q == '0) begin
							state_q <= PUSH_HEAD;
						end else begin
							j_q <= j_q - trpq_pkg::IDX_W'(1);
						end
					end else begin
						cnt_q   <= cnt_q + trpq_pkg::CNT_W'(1);
						res_q   <= '{trpq_pkg::ST_ACCEPTED, '0, '0,
							cnt_q + trpq_pkg::CNT_W'(1)};
						state_q <= RESP;
					end
				end
				PUSH_HEAD: begin
					cnt_q   <= cnt_q + trpq_pkg::CNT_W'(1);
					res_q   <= '{trpq_pkg::ST_ACCEPTED, '0, '0,
						cnt_q + trpq_pkg::CNT_W'(1)};
					state_q <= RESP;
				end
				PEEK_CHK: begin
					if (release_ok) begin
						cnt_q  <= cnt_q - trpq_pkg::CNT_W'(1);
						hd_q   <= hd_next;
						last_q <= now_q;
						res_q  <= '{trpq_pkg::ST_RELEASED, rd_data.rtime, rd_data.payload,
							cnt_q - trpq_pkg::CNT_W'(1)};
					end else begin
						res_q <= '{trpq_pkg::ST_WAIT, '0, '0, cnt_q};
					end
					state_q <= RESP;
				end
				RESP: begin
					if (res_ready) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("entry count beyond queue depth");

	a_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_en && cmd.rd_en) |-> (cmd.wr_idx != cmd.rd_idx))
		else $error("read and write hit the same entry in one cycle");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == PUSH_SCAN) |-> ({1'b0, j_q} < cnt_q))
		else $error("insert scan outside held entries");

	a_peek_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == PEEK_CHK) |-> (cnt_q != '0))
		else $error("head check on an empty queue");

	a_release_time: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == PEEK_CHK && release_ok) |=> (last_q == $past(now_q)))
		else $error("release did not record the current time");

endmodule

/* hdl/trpq_outreg.sv */
// one-entry result register between the sequencer and the master stream
// depends on trpq_pkg
module trpq_outreg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ld_valid,
	output logic              ld_ready,
	input  trpq_pkg::result_t ld_data,
	output logic              out_valid,
	input  logic              out_ready,
	output trpq_pkg::result_t out_data
);

	logic              vld_q;
	trpq_pkg::result_t data_q;

	assign ld_ready  = !vld_q || out_ready;
	assign out_valid = vld_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			data_q <= '0;
		end else if (ld_ready) begin
			vld_q <= ld_valid;
			if (ld_valid) begin
				data_q <= ld_data;
			end
		end
	end

endmodule

/* hdl/timed_release_priority_queue_top.sv */
// top level of the timed release priority queue
// depends on trpq_pkg, trpq_store, trpq_ctrl and trpq_outreg
//
// usage:
//  s_* stream carries requests: s_tuser is the request kind (push or peek),
//  s_tdata the release time, payload tag and current time.
//  m_* stream returns exactly one result transaction per request: m_tuser is
//  the status, m_tdata the released time, payload and entry count.
//  cfg_* writes min_interval (seconds between releases); always ready, write
//  only while no request is outstanding.
// timing: an empty peek or a full push goes from IDLE straight to RESP, a peek
//  passes PEEK_CHK, a push one PUSH_SCAN step per entry examined and PUSH_HEAD
//  when it lands at the head; each result then goes through the output register
//  to m_tvalid. A new request is taken once the previous result has moved to the
//  output register; the insert scan reads and writes once a cycle.
// reset: asynchronous, clears the queue to empty, last release time and
//  min_interval to zero; the entry memory keeps its contents, unused.
// stall: a result waits in the output register while m_tready is low; one
//  further request is worked on and then held until that register frees.
module timed_release_priority_queue_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// request stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [31:0] release_time, [63:32] payload_tag, [95:64] current_time
	input  logic [trpq_pkg::IN_TDATA_W-1:0]  s_tdata,
	// [0] req_type
	input  logic [0:0]                       s_tuser,
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [31:0] out_release_time, [63:32] out_payload, [68:64] entry_count, rest zero
	output logic [trpq_pkg::OUT_TDATA_W-1:0] m_tdata,
	// [2:0] status
	output logic [2:0]                       m_tuser,
	// configuration write
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [31:0]                      cfg_data
);

	logic [trpq_pkg::TIME_W-1:0]  min_interval_q;
	trpq_pkg::mem_cmd_t           cmd;
	logic [trpq_pkg::IDX_W-1:0]   head;
	trpq_pkg::entry_t             rd_data;
	logic                         res_valid;
	logic                         res_ready;
	trpq_pkg::result_t            res;
	trpq_pkg::result_t            out_res;

	// config register; cfg_ready is always high
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_interval_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			min_interval_q <= cfg_data;
		end
	end

	trpq_store u_store (
		.clk     (clk),
		.cmd     (cmd),
		.head    (head),
		.rd_data (rd_data)
	);

	trpq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_req       (trpq_pkg::req_t'(s_tuser[0])),
		.in_rtime     (s_tdata[31:0]),
		.in_tag       (s_tdata[63:32]),
		.in_now       (s_tdata[95:64]),
		.min_interval (min_interval_q),
		.cmd          (cmd),
		.head         (head),
		.rd_data      (rd_data),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	// output register parts the sequencer from the receiver
	trpq_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld_valid  (res_valid),
		.ld_ready  (res_ready),
		.ld_data   (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tuser = out_res.status;
	assign m_tdata = trpq_pkg::OUT_TDATA_W'({out_res.count, out_res.payload, out_res.rtime});

endmodule

/* test/tb_timed_release_priority_queue_top.sv */
// testbench for timed_release_priority_queue_top: directed and random push and peek
// transactions, every result checked against a cycle-free prediction of the table
// depends on trpq_pkg and timed_release_priority_queue_top from hdl
module tb_timed_release_priority_queue_top;
	timeunit 1ns;
	timeprecision 1ps;

	import trpq_pkg::*;

	// tracks the sorted notice table and the results it owes, in acceptance order
	class notice_table_tracker;
		logic [TIME_W-1:0] slot_time[QUEUE_DEPTH];
		logic [TAG_W-1:0]  slot_tag[QUEUE_DEPTH];
		int unsigned       held;
		logic [31:0]       last_release;
		logic [31:0]       min_interval;
		result_t           owed_results[$];
		int                errors;

		function new();
			held         = 0;
			last_release = '0;
			min_interval = '0;
			errors       = 0;
		endfunction

		// update the table for one accepted request and queue the result it causes
		function void take_request(req_t kind, logic [31:0] rtime, logic [31:0] tag,
				logic [31:0] now);
			result_t     res;
			logic [31:0] clamped;
			logic [31:0] gap;
			int unsigned pos;
			res = '0;
			if (kind == REQ_PUSH) begin
				clamped = rtime[31] ? '0 : rtime;
				if (held >= QUEUE_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					// land behind every entry that is due no later
					pos = 0;
					while (pos < held && slot_time[pos] <= clamped)
						pos++;
					for (int i = held; i > pos; i--) begin
						slot_time[i] = slot_time[i-1];
						slot_tag[i]  = slot_tag[i-1];
					end
					slot_time[pos] = clamped;
					slot_tag[pos]  = tag;
					held++;
					res.status = ST_ACCEPTED;
				end
			end else if (held == 0) begin
				res.status = ST_EMPTY;
			end else begin
				gap = now - last_release;
				if (now >= last_release && gap >= min_interval &&
						(slot_time[0] == '0 || slot_time[0] <= now)) begin
					res.status  = ST_RELEASED;
					res.rtime   = slot_time[0];
					res.payload = slot_tag[0];
					for (int i = 1; i < held; i++) begin
						slot_time[i-1] = slot_time[i];
						slot_tag[i-1]  = slot_tag[i];
					end
					held--;
					last_release = now;
				end else begin
					res.status = ST_WAIT;
				end
			end
			res.count = held[CNT_W-1:0];
			owed_results = {owed_results, res};
		endfunction

		// compare one result transaction with the oldest owed result
		function void match_result(logic [2:0] status, logic [OUT_TDATA_W-1:0] data);
			result_t want;
			if (owed_results.size() == 0) begin
				$error("result transaction with nothing outstanding: status %0d", status);
				errors++;
				return;
			end
			want = owed_results.pop_front();
			if (status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, status);
				errors++;
			end
			if (data[TIME_W-1:0] !== want.rtime) begin
				$error("out_release_time: expected %h, got %h", want.rtime,
					data[TIME_W-1:0]);
				errors++;
			end
			if (data[TIME_W+TAG_W-1:TIME_W] !== want.payload) begin
				$error("out_payload: expected %h, got %h", want.payload,
					data[TIME_W+TAG_W-1:TIME_W]);
				errors++;
			end
			if (data[TIME_W+TAG_W+CNT_W-1:TIME_W+TAG_W] !== want.count) begin
				$error("entry_count: expected %0d, got %0d", want.count,
					data[TIME_W+TAG_W+CNT_W-1:TIME_W+TAG_W]);
				errors++;
			end
			if (data[OUT_TDATA_W-1:TIME_W+TAG_W+CNT_W] !== '0) begin
				$error("tdata_pad: expected 0, got %h",
					data[OUT_TDATA_W-1:TIME_W+TAG_W+CNT_W]);
				errors++;
			end
		endfunction
	endclass

	// longest request-to-result time plus margin, used before config writes and at the end
	localparam int SETTLE_CYCLES = QUEUE_DEPTH + 8;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// [31:0] release_time, [63:32] payload_tag, [95:64] current_time
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	// [0] req_type
	logic [0:0]             s_tuser  = REQ_PUSH;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [31:0] out_release_time, [63:32] out_payload, [68:64] entry_count
	logic [OUT_TDATA_W-1:0] m_tdata;
	// [2:0] status
	logic [2:0]             m_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [31:0]            cfg_data  = '0;

	notice_table_tracker tracker = new();

	// idle and stall rates in percent, changed per phase
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	// share of pushes among random requests, re-rolled in bursts
	int unsigned push_bias      = 50;
	// wall clock the random peeks follow; only moves forward
	logic [31:0] clock_now      = '0;
	logic [31:0] recent_time    = 32'd5;

	timed_release_priority_queue_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver back-pressure, one decision per cycle
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// signals read here still hold their pre-edge values, so this sees the handshake
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.match_result(m_tuser, m_tdata);
	end

	// one request transaction, with random idle cycles ahead of it; valid stays
	// high on return so back-to-back requests need no second assignment
	task automatic send_request(req_t kind, logic [31:0] rtime, logic [31:0] tag,
			logic [31:0] now);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {now, tag, rtime};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.take_request(kind, rtime, tag, now);
	endtask

	// hold off the sender until every owed result is back, then let the block go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (tracker.owed_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_interval(logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		tracker.min_interval = value;
	endtask

	// one random request: pushes mostly near the wall clock so they come due,
	// peeks mostly on an advancing clock, some noise on both
	task automatic random_request();
		logic [31:0] rtime;
		logic [31:0] now;
		int unsigned pick;
		int unsigned step_cap;
		pick = $urandom_range(99);
		if ($urandom_range(99) < push_bias) begin
			if (pick < 45)
				rtime = clock_now + $urandom_range(60);
			else if (pick < 60)
				rtime = clock_now - $urandom_range(30);
			else if (pick < 72)
				rtime = recent_time;          // equal times keep arrival order
			else if (pick < 80)
				rtime = '0;
			else if (pick < 88)
				rtime = $urandom() | 32'h8000_0000;  // negative, clamps to zero
			else
				rtime = $urandom();
			recent_time = rtime;
			send_request(REQ_PUSH, rtime, $urandom(), $urandom());
		end else begin
			if (tracker.last_release > clock_now)
				clock_now = tracker.last_release;
			step_cap = (tracker.min_interval > 64) ? 8 : tracker.min_interval * 2 + 4;
			if (pick < 6) begin
				// a time at or behind the wall clock, possibly before the last release
				now = $urandom_range(clock_now);
			end else begin
				clock_now = clock_now + $urandom_range(step_cap);
				now = clock_now;
			end
			send_request(REQ_PEEK, $urandom(), $urandom(), now);
		end
	endtask

	// watchdog
	initial begin
		#1_000_000;
		$display("FAIL timed_release_priority_queue_top");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] interval_of[6];
		int unsigned idle_of[6];
		int unsigned stall_of[6];
		int unsigned items_of[6];
		logic [31:0] base_of[6];
		interval_of = '{32'd0, 32'd5, 32'hFFFF_FFFF, 32'd20, 32'd1, 32'd3};
		idle_of     = '{0, 81, 6, 0, 6, 0};
		stall_of    = '{0, 0, 6, 81, 6, 0};
		items_of    = '{400, 300, 60, 300, 340, 340};
		base_of     = '{32'h0000_0100, 32'h1000_0000, 32'h1000_0000, 32'h4000_0000,
			32'h7FFF_FF00, 32'hC000_0000};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, min_interval still at its reset value of zero
		send_idle_pct  = 6;
		recv_stall_pct = 6;
		send_request(REQ_PEEK, $urandom(), $urandom(), 32'hFFFF_FFFF);  // empty table
		send_request(REQ_PUSH, 32'h8000_0000, 32'hFFFF_FFFF, $urandom()); // most negative
		send_request(REQ_PUSH, 32'h7FFF_FFFF, 32'h0000_0000, $urandom()); // largest time
		send_request(REQ_PUSH, 32'hFFFF_FFFF, 32'h0000_0001, $urandom()); // minus one
		send_request(REQ_PUSH, 32'd5, 32'h50, $urandom());
		send_request(REQ_PUSH, 32'd5, 32'h51, $urandom());
		send_request(REQ_PUSH, 32'd5, 32'h52, $urandom());
		send_request(REQ_PUSH, 32'd3, 32'h30, $urandom());
		send_request(REQ_PEEK, $urandom(), $urandom(), 32'd10);  // zero-time head goes
		send_request(REQ_PEEK, $urandom(), $urandom(), 32'd9);   // behind last release
		send_request(REQ_PEEK, $urandom(), $urandom(), 32'd10);  // second zero-time head
		send_request(REQ_PEEK, $urandom(), $urandom(), 32'd10);  // time 3 head
		// fill to the top, then one push into the full table
		for (int i = 0; i < 13; i++)
			send_request(REQ_PUSH, (i == 6) ? 32'd5 : $urandom_range(100), $urandom(),
				$urandom());
		settle();

		// random part, one register setting per phase
		for (int p = 0; p < 6; p++) begin
			write_interval(interval_of[p]);
			send_idle_pct  = idle_of[p];
			recv_stall_pct = stall_of[p];
			if (clock_now < base_of[p])
				clock_now = base_of[p];
			for (int n = 0; n < items_of[p]; n++) begin
				if (n % 40 == 0) begin
					case ($urandom_range(2))
						0: begin
							push_bias = 20;
						end
						1: begin
							push_bias = 50;
						end
						default: begin
							push_bias = 80;
						end
					endcase
				end
				random_request();
			end
			settle();
		end

		if (tracker.errors == 0) begin
			$display("PASS timed_release_priority_queue_top");
		end else begin
			$display("FAIL timed_release_priority_queue_top");
		end
		$finish;
	end

endmodule
